// ===== rtl/laser_safety_fault_supervisor_top_macros.svh =====
// Assertion macros for the laser safety fault supervisor.
`ifndef LASER_SAFETY_FAULT_SUPERVISOR_TOP_MACROS_SVH
`define LASER_SAFETY_FAULT_SUPERVISOR_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define LSFS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define LSFS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/lsfs_pkg.sv =====
// Types and constants shared by the laser safety fault supervisor.
package lsfs_pkg;

	// Sequencer modes
	localparam logic [2:0] MODE_PU_TEC = 3'd1;
	localparam logic [2:0] MODE_PU_LD  = 3'd2;
	localparam logic [2:0] MODE_READY  = 3'd3;
	localparam logic [2:0] MODE_FIRING = 3'd4;

	// Fault bit positions and groups
	localparam int FLT_USAGE    = 0;
	localparam int FLT_LD_TEC   = 1;
	localparam int FLT_PWR_DROP = 2;
	localparam int FLT_TIMEOUT  = 3;
	localparam logic [3:0] FLT_USAGE_MASK    = 4'h1;
	localparam logic [3:0] FLT_INTERNAL_MASK = 4'hE;

	// Safety bit positions
	localparam int SB_PWR_TEC = 0;
	localparam int SB_PWR_LD  = 1;
	localparam int SB_TEC_OK  = 2;
	localparam int SB_LD_OK   = 3;
	localparam int SB_IMU     = 4;
	localparam logic [4:0] SB_ALL = 5'h1F;

	// Source indexes
	localparam int SRC_PWR = 0;
	localparam int SRC_TEC = 1;
	localparam int SRC_LD  = 2;
	localparam int SRC_IMU = 3;
	localparam int NUM_SRC = 4;

	// Register indexes
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] CFG_PWR_STALE   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TEC_STALE   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_LD_STALE    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_IMU_STALE   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_TEC_PU_LIM  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_LD_PU_LIM   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_REL_SAMPLES = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_CLR_IMU     = 3'd7;
	localparam int CFG_DATA_W = 16;

	// Register reset values
	localparam logic [15:0] STALE_RESET    = 16'd10;
	localparam logic [15:0] PU_LIMIT_RESET = 16'd150;
	localparam logic [7:0]  REL_RESET      = 8'd3;

	localparam logic [7:0]  RELEASE_MAX  = 8'd255;
	localparam logic [15:0] MODE_AGE_MAX = 16'hFFFF;

	typedef struct packed {
		logic       pwr_update;
		logic       pwr_tec_ready_in;
		logic       pwr_ld_ready_in;
		logic       tec_update;
		logic       tec_ok_in;
		logic       ld_update;
		logic       ld_ok_in;
		logic       imu_update;
		logic       imu_valid_in;
		logic       imu_orient_ok_in;
		logic       trigger;
		logic [2:0] mode_now;
	} lsfs_item_t;

	typedef struct packed {
		logic [4:0] safe_vec;
		logic       permit;
		logic [3:0] fault_bits;
		logic       internal_fault;
		logic       usage_fault;
		logic       clr_internal;
		logic       clr_usage;
	} lsfs_result_t;

	typedef struct packed {
		logic [15:0] pwr_stale_ticks;
		logic [15:0] tec_stale_ticks;
		logic [15:0] ld_stale_ticks;
		logic [15:0] imu_stale_ticks;
		logic [15:0] tec_powerup_limit;
		logic [15:0] ld_powerup_limit;
		logic [7:0]  release_samples;
		logic        clr_need_imu;
	} lsfs_cfg_t;

	// Fault unit outcome for one tick
	typedef struct packed {
		logic [3:0] fault_bits;
		logic       clr_internal;
		logic       clr_usage;
	} lsfs_fault_t;

endpackage

// ===== rtl/lsfs_cfg.sv =====
// Configuration register file of the laser safety fault supervisor.
module lsfs_cfg import lsfs_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr_en,
	input  logic [CFG_IDX_W-1:0] wr_index,
	input  logic [CFG_DATA_W-1:0] wr_data,
	output lsfs_cfg_t            cfg
);

	lsfs_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pwr_stale_ticks      <= STALE_RESET;
			cfg_q.tec_stale_ticks      <= STALE_RESET;
			cfg_q.ld_stale_ticks       <= STALE_RESET;
			cfg_q.imu_stale_ticks      <= STALE_RESET;
			cfg_q.tec_powerup_limit    <= PU_LIMIT_RESET;
			cfg_q.ld_powerup_limit     <= PU_LIMIT_RESET;
			cfg_q.release_samples      <= REL_RESET;
			cfg_q.clr_need_imu         <= 1'b1;
		end else if (wr_en) begin
			unique case (wr_index)
				CFG_PWR_STALE:   cfg_q.pwr_stale_ticks      <= wr_data;
				CFG_TEC_STALE:   cfg_q.tec_stale_ticks      <= wr_data;
				CFG_LD_STALE:    cfg_q.ld_stale_ticks       <= wr_data;
				CFG_IMU_STALE:   cfg_q.imu_stale_ticks      <= wr_data;
				CFG_TEC_PU_LIM:  cfg_q.tec_powerup_limit    <= wr_data;
				CFG_LD_PU_LIM:   cfg_q.ld_powerup_limit     <= wr_data;
				CFG_REL_SAMPLES: cfg_q.release_samples      <= wr_data[7:0];
				CFG_CLR_IMU:     cfg_q.clr_need_imu         <= wr_data[0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== rtl/lsfs_fresh.sv =====
// Source status latch and freshness ageing; forms the qualified safety bits.
module lsfs_fresh import lsfs_pkg::*; #(
	parameter int AGE_WIDTH = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       adv,
	input  lsfs_item_t item,
	input  lsfs_cfg_t  cfg,
	output logic [4:0] safe_vec
);

	localparam int CMP_W = (AGE_WIDTH > 16) ? AGE_WIDTH : 16;

	logic [AGE_WIDTH-1:0] age_q   [NUM_SRC];
	logic [AGE_WIDTH-1:0] age_nxt [NUM_SRC];
	logic [NUM_SRC-1:0]   seen_q, seen_nxt, upd, fresh;
	logic [15:0]          stale   [NUM_SRC];
	logic [5:0]           val_q, val_nxt;

	assign upd[SRC_PWR] = item.pwr_update;
	assign upd[SRC_TEC] = item.tec_update;
	assign upd[SRC_LD]  = item.ld_update;
	assign upd[SRC_IMU] = item.imu_update;

	assign stale[SRC_PWR] = cfg.pwr_stale_ticks;
	assign stale[SRC_TEC] = cfg.tec_stale_ticks;
	assign stale[SRC_LD]  = cfg.ld_stale_ticks;
	assign stale[SRC_IMU] = cfg.imu_stale_ticks;

	// Latch reported values of the sources that updated
	always_comb begin
		val_nxt = val_q;
		if (item.pwr_update) begin
			val_nxt[0] = item.pwr_tec_ready_in;
			val_nxt[1] = item.pwr_ld_ready_in;
		end
		if (item.tec_update) val_nxt[2] = item.tec_ok_in;
		if (item.ld_update)  val_nxt[3] = item.ld_ok_in;
		if (item.imu_update) begin
			val_nxt[4] = item.imu_valid_in;
			val_nxt[5] = item.imu_orient_ok_in;
		end
	end

	for (genvar i = 0; i < NUM_SRC; i++) begin : g_src
		always_comb begin
			if (upd[i]) begin
				age_nxt[i] = '0;
			end else if (age_q[i] != {AGE_WIDTH{1'b1}}) begin
				age_nxt[i] = age_q[i] + 1'b1;
			end else begin
				age_nxt[i] = age_q[i];
			end
			seen_nxt[i] = seen_q[i] | upd[i];
			fresh[i] = seen_nxt[i] && (CMP_W'(age_nxt[i]) <= CMP_W'(stale[i]));
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				age_q[i]  <= '0;
				seen_q[i] <= 1'b0;
			end else if (adv) begin
				age_q[i]  <= age_nxt[i];
				seen_q[i] <= seen_nxt[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			val_q <= '0;
		end else if (adv) begin
			val_q <= val_nxt;
		end
	end

	assign safe_vec[SB_PWR_TEC] = fresh[SRC_PWR] & val_nxt[0];
	assign safe_vec[SB_PWR_LD]  = fresh[SRC_PWR] & val_nxt[1];
	assign safe_vec[SB_TEC_OK]  = fresh[SRC_TEC] & val_nxt[2];
	assign safe_vec[SB_LD_OK]   = fresh[SRC_LD]  & val_nxt[3];
	assign safe_vec[SB_IMU]     = fresh[SRC_IMU] & val_nxt[4] & val_nxt[5];

endmodule

// ===== rtl/lsfs_fault.sv =====
// Mode timer, fault latch, trigger release counter and group clearing.
module lsfs_fault import lsfs_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        adv,
	input  logic [2:0]  mode_now,
	input  logic        trigger,
	input  logic [4:0]  safe_vec,
	input  lsfs_cfg_t   cfg,
	output lsfs_fault_t fault
);

	logic [15:0] mode_age_q, mode_age_nxt;
	logic [2:0]  mode_last_q;
	logic [7:0]  rel_q, rel_nxt;
	logic [3:0]  fault_q, fault_set, fault_nxt;
	logic        pwr_good, tec_ok, ld_ok, imu_good;
	logic        rel_met, clear_ok, clr_int, clr_use;

	assign pwr_good = safe_vec[SB_PWR_TEC] & safe_vec[SB_PWR_LD];
	assign tec_ok   = safe_vec[SB_TEC_OK];
	assign ld_ok    = safe_vec[SB_LD_OK];
	assign imu_good = safe_vec[SB_IMU];

	always_comb begin
		if (mode_now != mode_last_q) begin
			mode_age_nxt = 16'd1;
		end else if (mode_age_q != MODE_AGE_MAX) begin
			mode_age_nxt = mode_age_q + 16'd1;
		end else begin
			mode_age_nxt = mode_age_q;
		end

		fault_set = fault_q;
		case (mode_now)
			MODE_FIRING: begin
				if (!imu_good)          fault_set[FLT_USAGE]    = 1'b1;
				if (!ld_ok || !tec_ok)  fault_set[FLT_LD_TEC]   = 1'b1;
				if (!pwr_good)          fault_set[FLT_PWR_DROP] = 1'b1;
			end
			MODE_READY: begin
				if (!pwr_good)          fault_set[FLT_PWR_DROP] = 1'b1;
			end
			MODE_PU_TEC: begin
				if (mode_age_nxt > cfg.tec_powerup_limit) fault_set[FLT_TIMEOUT] = 1'b1;
			end
			MODE_PU_LD: begin
				if (mode_age_nxt > cfg.ld_powerup_limit)  fault_set[FLT_TIMEOUT] = 1'b1;
			end
			default: ;
		endcase

		if (trigger) begin
			rel_nxt = '0;
		end else if (rel_q != RELEASE_MAX) begin
			rel_nxt = rel_q + 8'd1;
		end else begin
			rel_nxt = rel_q;
		end

		rel_met    = rel_nxt >= cfg.release_samples;
		clear_ok   = cfg.clr_need_imu ? imu_good : 1'b1;
		clr_int    = (|(fault_set & FLT_INTERNAL_MASK)) & clear_ok & rel_met;
		clr_use    = (|(fault_set & FLT_USAGE_MASK)) & clear_ok & rel_met;

		fault_nxt = fault_set;
		if (clr_int) fault_nxt = fault_nxt & ~FLT_INTERNAL_MASK;
		if (clr_use) fault_nxt = fault_nxt & ~FLT_USAGE_MASK;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_age_q  <= '0;
			mode_last_q <= '0;
			rel_q       <= '0;
			fault_q     <= '0;
		end else if (adv) begin
			mode_age_q  <= mode_age_nxt;
			mode_last_q <= mode_now;
			rel_q       <= rel_nxt;
			fault_q     <= fault_nxt;
		end
	end

	assign fault.fault_bits   = fault_nxt;
	assign fault.clr_internal = clr_int;
	assign fault.clr_usage    = clr_use;

endmodule

// ===== rtl/laser_safety_fault_supervisor_top.sv =====
// Top level of the laser safety fault supervisor.
//
//  Channel   | Handshake                | Payload
//  ----------+--------------------------+------------------------------
//  item      | item_valid / item_stall   | item   (lsfs_item_t)
//  result    | result_valid / result_stall | result (lsfs_result_t)
//  cfg       | cfg_valid / cfg_ready     | cfg_index, cfg_data
//
//  One tick per clock cycle sustained while the result side does not stall. An
//  accepted tick is held in the input register, and all of its work (ageing,
//  fault latch, release count, clearing) is computed from there into the
//  result register. Reset clears ages, seen flags, latched values, faults and
//  counters, and loads the register defaults. A stalled result holds the input
//  register; item_stall rises only while the input register is occupied and
//  the result register holds a stalled result.
`include "laser_safety_fault_supervisor_top_macros.svh"

module laser_safety_fault_supervisor_top import lsfs_pkg::*; #(
	parameter int AGE_WIDTH = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  item_valid,
	output logic                  item_stall,
	input  lsfs_item_t            item,
	output logic                  result_valid,
	input  logic                  result_stall,
	output lsfs_result_t          result,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	lsfs_cfg_t    cfg;
	lsfs_item_t   item_s1;
	logic         valid_s1;
	logic         adv;
	logic         out_free;
	logic [4:0]   safe_vec;
	lsfs_fault_t  fault;
	lsfs_result_t res_nxt;
	lsfs_result_t result_q;
	logic         result_valid_q;

	// Registers accept a write in any cycle
	assign cfg_ready = 1'b1;

	lsfs_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid & cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// The result register can take a new tick when empty or being drained
	assign out_free   = !result_valid_q || !result_stall;
	assign adv        = valid_s1 && out_free;
	// Hold off the source only while the input register cannot move on
	assign item_stall = valid_s1 && !out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			valid_s1 <= item_valid;
		end
	end

	// Payload capture on every input transfer
	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			item_s1 <= item;
		end
	end

	lsfs_fresh #(
		.AGE_WIDTH (AGE_WIDTH)
	) u_fresh (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.item     (item_s1),
		.cfg      (cfg),
		.safe_vec (safe_vec)
	);

	lsfs_fault u_fault (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.mode_now (item_s1.mode_now),
		.trigger  (item_s1.trigger),
		.safe_vec (safe_vec),
		.cfg      (cfg),
		.fault    (fault)
	);

	// Assemble the result; permit needs all safety bits and a clean fault store
	always_comb begin
		res_nxt.safe_vec       = safe_vec;
		res_nxt.permit         = (safe_vec == SB_ALL) && (fault.fault_bits == 4'h0);
		res_nxt.fault_bits     = fault.fault_bits;
		res_nxt.internal_fault = |(fault.fault_bits & FLT_INTERNAL_MASK);
		res_nxt.usage_fault    = |(fault.fault_bits & FLT_USAGE_MASK);
		res_nxt.clr_internal   = fault.clr_internal;
		res_nxt.clr_usage      = fault.clr_usage;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (out_free) begin
			result_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			result_q <= res_nxt;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	// Checks
	`LSFS_ASSERT_NOW(a_permit_clean, clk, arst_n, result_valid && result.permit, (result.safe_vec == SB_ALL) && (result.fault_bits == 4'h0), "permit with a fault or missing safety bit")
	`LSFS_ASSERT_NOW(a_clear_empties, clk, arst_n, result_valid && result.clr_internal, !result.internal_fault, "internal group still set after clear")
	`LSFS_ASSERT_NOW(a_stall_only_blocked, clk, arst_n, item_stall, result_valid && result_stall, "input stalled while result side free")

endmodule
